// File: design/mcfc_pkg.sv
// ----------------------------------------------------------------------------
// Motor command fault controller package
// Shared event codes, reply codes, motor mode codes and register constants.
// ----------------------------------------------------------------------------
package mcfc_pkg;

  // Field widths of events, replies, periods and the register bus.
  localparam int unsigned OpcodeWidth = 3;
  localparam int unsigned ReplyWidth  = 3;
  localparam int unsigned ModeWidth   = 2;
  localparam int unsigned PeriodWidth = 16;
  localparam int unsigned AddrWidth   = 3;
  localparam int unsigned DataWidth   = 32;

  typedef logic [OpcodeWidth-1:0] opcode_t;
  typedef logic [ReplyWidth-1:0]  reply_t;
  typedef logic [ModeWidth-1:0]   mode_t;
  typedef logic [PeriodWidth-1:0] period_t;

  // Event codes.
  localparam opcode_t OP_TICK     = 3'd0;
  localparam opcode_t OP_START    = 3'd1;
  localparam opcode_t OP_STOP     = 3'd2;
  localparam opcode_t OP_STATUS   = 3'd3;
  localparam opcode_t OP_UNKNOWN  = 3'd4;
  localparam opcode_t OP_CHECKSUM = 3'd5;
  localparam opcode_t OP_BUTTON   = 3'd6;

  // Reply codes.
  localparam reply_t REPLY_NONE      = 3'd0;
  localparam reply_t REPLY_ACK       = 3'd1;
  localparam reply_t REPLY_FAULT     = 3'd2;
  localparam reply_t REPLY_STATUS    = 3'd3;
  localparam reply_t REPLY_HEARTBEAT = 3'd4;

  // Motor mode codes.
  localparam mode_t MODE_IDLE    = 2'd0;
  localparam mode_t MODE_RUNNING = 2'd1;
  localparam mode_t MODE_FAULT   = 2'd2;

  // Register indexes (taken from paddr[2]) and reset values.
  localparam logic REG_HEARTBEAT_PERIOD = 1'b0;
  localparam logic REG_BLINK_PERIOD     = 1'b1;

  localparam period_t HEARTBEAT_PERIOD_RESET = 16'd500;
  localparam period_t BLINK_PERIOD_RESET     = 16'd200;

endpackage

// File: design/mcfc_stream_if.sv
// ----------------------------------------------------------------------------
// Motor command fault controller channels
// Valid/ready event channel and reply channel with their payloads.
// ----------------------------------------------------------------------------

// Event channel: one transaction carries one event.
interface mcfc_cmd_if
  import mcfc_pkg::*;
  ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  logic    button_level;

  modport source (output valid, output opcode, output button_level, input ready);
  modport sink   (input valid, input opcode, input button_level, output ready);
endinterface

// Reply channel: one transaction carries one reply.
interface mcfc_rsp_if
  import mcfc_pkg::*;
  ();
  logic   valid;
  logic   ready;
  reply_t reply_kind;
  mode_t  status_value;
  logic   led_level;

  modport source (output valid, output reply_kind, output status_value,
                  output led_level, input ready);
  modport sink   (input valid, input reply_kind, input status_value,
                  input led_level, output ready);
endinterface

// File: design/motor_command_fault_controller.sv
// ----------------------------------------------------------------------------
// Motor command fault controller
// Latency: a reply is valid in the cycle after its event transaction.
// Throughput: one event per cycle; the single reply register is refilled in
// the same cycle it is taken, so the event channel stalls only on reply stall.
// Reset (rst, synchronous, active high): idle mode, counters cleared, LED off,
// button released, periods 500 and 200, reply register empty.
// ----------------------------------------------------------------------------
module motor_command_fault_controller
  import mcfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  mcfc_cmd_if.sink             cmd,
  mcfc_rsp_if.source           rsp,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  // Configuration registers.
  period_t heartbeat_period;
  period_t blink_period;

  // Controller state.
  mode_t   motor_mode;
  period_t heartbeat_elapsed;
  period_t blink_elapsed;
  logic    blink_phase;
  logic    led_pin;
  logic    button_last;

  // Reply register.
  logic    out_valid;
  reply_t  out_reply;
  mode_t   out_status;
  logic    out_led;

  // Next values.
  mode_t   motor_mode_next;
  period_t heartbeat_elapsed_next;
  period_t blink_elapsed_next;
  logic    blink_phase_next;
  logic    led_pin_next;
  logic    button_last_next;
  reply_t  reply_next;
  mode_t   status_next;

  logic    accept;
  logic    cfg_write;
  period_t hb_eff;
  period_t bl_eff;
  period_t hb_count;
  period_t bl_count;

  // Handshakes.
  assign cmd.ready = !out_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_period <= HEARTBEAT_PERIOD_RESET;
      blink_period     <= BLINK_PERIOD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_HEARTBEAT_PERIOD) begin
        heartbeat_period <= pwdata[PeriodWidth-1:0];
      end else begin
        blink_period <= pwdata[PeriodWidth-1:0];
      end
    end
  end

  // Register reads.
  always_comb begin
    if (paddr[2] == REG_HEARTBEAT_PERIOD) begin
      prdata = {{(DataWidth-PeriodWidth){1'b0}}, heartbeat_period};
    end else begin
      prdata = {{(DataWidth-PeriodWidth){1'b0}}, blink_period};
    end
  end

  // A period of zero behaves as one; counters step up and saturate there.
  assign hb_eff   = (heartbeat_period == '0) ? period_t'(1) : heartbeat_period;
  assign bl_eff   = (blink_period == '0) ? period_t'(1) : blink_period;
  assign hb_count = (heartbeat_elapsed < hb_eff) ? heartbeat_elapsed + period_t'(1) : hb_eff;
  assign bl_count = (blink_elapsed < bl_eff) ? blink_elapsed + period_t'(1) : bl_eff;

  // Event decode and state update.
  always_comb begin
    motor_mode_next        = motor_mode;
    heartbeat_elapsed_next = heartbeat_elapsed;
    blink_elapsed_next     = blink_elapsed;
    blink_phase_next       = blink_phase;
    led_pin_next           = led_pin;
    button_last_next       = button_last;
    reply_next             = REPLY_NONE;
    status_next            = MODE_IDLE;

    unique case (cmd.opcode)
      OP_TICK: begin
        heartbeat_elapsed_next = hb_count;
        blink_elapsed_next     = bl_count;
        if (motor_mode == MODE_FAULT && bl_count >= bl_eff) begin
          blink_elapsed_next = '0;
          blink_phase_next   = !blink_phase;
          led_pin_next       = !blink_phase;
        end
        if (motor_mode == MODE_RUNNING && hb_count >= hb_eff) begin
          heartbeat_elapsed_next = '0;
          reply_next             = REPLY_HEARTBEAT;
        end
      end
      OP_START: begin
        if (motor_mode == MODE_FAULT) begin
          reply_next = REPLY_FAULT;
        end else begin
          motor_mode_next        = MODE_RUNNING;
          heartbeat_elapsed_next = '0;
          reply_next             = REPLY_ACK;
        end
      end
      OP_STOP: begin
        motor_mode_next = MODE_IDLE;
        reply_next      = REPLY_ACK;
      end
      OP_STATUS: begin
        reply_next  = REPLY_STATUS;
        status_next = motor_mode;
      end
      OP_BUTTON: begin
        // A falling edge on the active-low button is an emergency stop.
        if (button_last && !cmd.button_level) begin
          motor_mode_next = MODE_FAULT;
          reply_next      = REPLY_FAULT;
        end
        button_last_next = cmd.button_level;
      end
      default: begin
        // Unknown command, checksum error and the unused code all fault.
        motor_mode_next = MODE_FAULT;
        reply_next      = REPLY_FAULT;
      end
    endcase

    // The LED follows the mode outside fault.
    if (motor_mode_next == MODE_RUNNING) begin
      led_pin_next = 1'b1;
    end else if (motor_mode_next == MODE_IDLE) begin
      led_pin_next = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_mode        <= MODE_IDLE;
      heartbeat_elapsed <= '0;
      blink_elapsed     <= '0;
      blink_phase       <= 1'b0;
      led_pin           <= 1'b0;
      button_last       <= 1'b1;
    end else if (accept) begin
      motor_mode        <= motor_mode_next;
      heartbeat_elapsed <= heartbeat_elapsed_next;
      blink_elapsed     <= blink_elapsed_next;
      blink_phase       <= blink_phase_next;
      led_pin           <= led_pin_next;
      button_last       <= button_last_next;
    end
  end

  // Reply register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Reply register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_reply  <= reply_next;
      out_status <= status_next;
      out_led    <= led_pin_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.reply_kind   = out_reply;
  assign rsp.status_value = out_status;
  assign rsp.led_level    = out_led;

  // Every accepted event leaves a reply pending in the next cycle.
  a_accept_gives_reply: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted event produced no reply");

  // The LED is lit while running and dark while idle.
  a_led_follows_mode: assert property (@(posedge clk) disable iff (rst)
    (motor_mode == MODE_RUNNING |-> led_pin) and
    (motor_mode == MODE_IDLE |-> !led_pin))
    else $error("LED level disagrees with motor mode");

  // A pending fault reply means the controller sits in fault.
  a_fault_reply_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reply == REPLY_FAULT |-> motor_mode == MODE_FAULT)
    else $error("fault reply while not in fault mode");

  // Status value is zero on every reply that is not a status response.
  a_status_only_on_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reply != REPLY_STATUS |-> out_status == MODE_IDLE)
    else $error("status value set on a non-status reply");

  // A granted start runs the motor and restarts heartbeat timing.
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == OP_START && motor_mode != MODE_FAULT |=>
    motor_mode == MODE_RUNNING && heartbeat_elapsed == '0 && out_reply == REPLY_ACK)
    else $error("start did not run the motor");

endmodule
